[sv/nfa_pkg.sv]
// Package of the next-fit number allocator.
// Holds the request codes and the sequencer states; depends on nothing.
package nfa_pkg;

  localparam int ACTION_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_t;

endpackage

[sv/next_fit_number_allocator.sv]
// Top level of the next-fit number allocator: used map memory and its sequencer.
// Depends on nfa_pkg for the request codes and the sequencer states.
//
// After reset the block clears its used map, one entry per cycle, and holds busy
// high until every entry is cleared. A beat is taken when start is high and busy
// is low. Release and query with a valid number hold busy high for the resolve
// state; a number of zero or above COUNT, or an unused action code, is answered
// without raising busy. Allocate checks one map bit per cycle through the single
// read port of the used map, so it keeps busy high until a free candidate is found
// or every number has been checked. The result beat appears on done with success
// and granted in the same cycle that busy falls (or in the cycle after the beat
// when busy is not raised), for exactly one cycle, and cannot be held off.
module next_fit_number_allocator #(
  parameter int COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [nfa_pkg::ACTION_W-1:0]   action,
  input  logic [$clog2(COUNT+1)-1:0]     number,
  output logic                           done,
  output logic                           success,
  output logic [$clog2(COUNT+1)-1:0]     granted
);
  import nfa_pkg::*;

  localparam int NW = $clog2(COUNT + 1);
  localparam int AW = $clog2(COUNT);
  localparam logic [NW-1:0] COUNT_N = NW'(COUNT);
  localparam logic [NW-1:0] ONE_N = NW'(1);
  localparam logic [AW-1:0] LAST_A = AW'(COUNT - 1);

  logic used_mem [COUNT];
  logic rd_data;
  logic mem_we;
  logic mem_wd;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] rd_addr;

  state_t state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [NW-1:0] cand, cand_next;
  logic [NW-1:0] chk_cand, chk_cand_next;
  logic chk_valid, chk_valid_next;
  logic [NW-1:0] issued, issued_next;
  logic [NW-1:0] last_granted, last_granted_next;
  logic op_release, op_release_next;
  logic done_next, success_next;
  logic [NW-1:0] granted_next;

  logic [NW-1:0] cand_m1, chk_m1, num_m1, start_cand;
  logic num_ok;

  assign cand_m1 = cand - ONE_N;
  assign chk_m1 = chk_cand - ONE_N;
  assign num_m1 = number - ONE_N;
  assign num_ok = (number != '0) && (number <= COUNT_N);
  assign start_cand = (last_granted >= COUNT_N) ? ONE_N : last_granted + ONE_N;
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_wa] <= mem_wd;
    end
    rd_data <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      last_granted <= '0;
      chk_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      clr_addr <= clr_addr_next;
      last_granted <= last_granted_next;
      chk_valid <= chk_valid_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cand <= cand_next;
    chk_cand <= chk_cand_next;
    issued <= issued_next;
    op_release <= op_release_next;
    success <= success_next;
    granted <= granted_next;
  end

  always_comb begin
    state_next = state;
    clr_addr_next = clr_addr;
    cand_next = cand;
    chk_cand_next = chk_cand;
    chk_valid_next = chk_valid;
    issued_next = issued;
    last_granted_next = last_granted;
    op_release_next = op_release;
    done_next = 1'b0;
    success_next = 1'b0;
    granted_next = '0;
    mem_we = 1'b0;
    mem_wd = 1'b0;
    mem_wa = chk_m1[AW-1:0];
    rd_addr = cand_m1[AW-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        if (clr_addr == LAST_A) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end
      ST_IDLE: begin
        rd_addr = num_m1[AW-1:0];
        if (start) begin
          case (action_t'(action)) inside
            ACT_ALLOC: begin
              cand_next = start_cand;
              issued_next = '0;
              chk_valid_next = 1'b0;
              state_next = ST_SCAN;
            end
            ACT_RELEASE, ACT_QUERY: begin
              op_release_next = (action_t'(action) == ACT_RELEASE);
              chk_cand_next = number;
              if (num_ok) begin
                state_next = ST_RESOLVE;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (chk_valid && !rd_data) begin
          mem_we = 1'b1;
          mem_wd = 1'b1;
          last_granted_next = chk_cand;
          done_next = 1'b1;
          success_next = 1'b1;
          granted_next = chk_cand;
          chk_valid_next = 1'b0;
          state_next = ST_IDLE;
        end else if (issued == COUNT_N) begin
          done_next = 1'b1;
          chk_valid_next = 1'b0;
          state_next = ST_IDLE;
        end else begin
          chk_cand_next = cand;
          chk_valid_next = 1'b1;
          issued_next = issued + ONE_N;
          cand_next = (cand >= COUNT_N) ? ONE_N : cand + ONE_N;
        end
      end
      ST_RESOLVE: begin
        done_next = 1'b1;
        success_next = rd_data;
        if (op_release && rd_data) begin
          mem_we = 1'b1;
          mem_wd = 1'b0;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[verif/number_map_model_pkg.sv]
// Reply predictor for the next-fit number allocator testbench.
// Holds its own copy of the used map and the last number granted.
// Depends on nfa_pkg for the request codes.
package number_map_model_pkg;

  import nfa_pkg::*;

  localparam int NUMBERS = 64;

  typedef struct packed {
    logic       success;
    logic [6:0] granted;
  } reply_t;

  class number_map_model;

    bit         used_map [1:NUMBERS];
    int         last_granted;
    reply_t     replies_due [$];
    int         errors;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      last_granted = 0;
      errors = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void note_request(action_t act, logic [6:0] num);
      reply_t reply;
      int     cand;
      int     k;
      bit     in_range;
      reply = '0;
      in_range = (num >= 1) && (num <= NUMBERS);
      case (act)
        ACT_ALLOC: begin
          cand = (last_granted >= NUMBERS) ? 1 : last_granted + 1;
          for (k = 0; k < NUMBERS; k++) begin
            if (!used_map[cand]) begin
              used_map[cand] = 1'b1;
              last_granted = cand;
              reply.success = 1'b1;
              reply.granted = 7'(cand);
              break;
            end
            cand = (cand >= NUMBERS) ? 1 : cand + 1;
          end
        end
        ACT_RELEASE: begin
          if (in_range && used_map[num]) begin
            used_map[num] = 1'b0;
            reply.success = 1'b1;
          end
        end
        ACT_QUERY: begin
          if (in_range && used_map[num]) reply.success = 1'b1;
        end
        default: begin
        end
      endcase
      replies_due.push_back(reply);
    endfunction

    function void check_reply(logic success, logic [6:0] granted);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("reply beat with none due: success %0b granted %0d", success, granted);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (success !== want.success) begin
        $error("success: expected %0b, got %0b", want.success, success);
        errors++;
      end
      if (granted !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, granted);
        errors++;
      end
    endfunction

  endclass

endpackage

[verif/tb_top.sv]
// Testbench top for the next-fit number allocator: drives directed and random
// requests, predicts every reply beat and checks it field by field.
// Depends on nfa_pkg, number_map_model_pkg and next_fit_number_allocator.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import nfa_pkg::*;
  import number_map_model_pkg::*;

  localparam int QUIET_LIMIT = 3000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] action = ACT_NONE;
  logic [6:0] number = 7'd0;
  logic       busy;
  logic       done;
  logic       success;
  logic [6:0] granted;

  number_map_model tracker;
  int              idle_pct = 0;
  int unsigned     quiet_cycles = 0;

  next_fit_number_allocator #(.COUNT(NUMBERS)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .number(number),
    .done(done),
    .success(success),
    .granted(granted)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_reply(success, granted);
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(input action_t act, input logic [6:0] num);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      action <= 2'($urandom_range(3));
      number <= 7'($urandom_range(127));
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    number <= num;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(act, num);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  initial begin
    int         alloc_pct;
    int         roll;
    action_t    act;
    logic [6:0] num;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 37;
    issue(ACT_QUERY, 7'd1);
    issue(ACT_RELEASE, 7'd1);
    issue(ACT_ALLOC, 7'd0);
    issue(ACT_ALLOC, 7'd127);
    issue(ACT_QUERY, 7'd2);
    issue(ACT_QUERY, 7'd0);
    issue(ACT_QUERY, 7'd64);
    issue(ACT_QUERY, 7'd65);
    issue(ACT_RELEASE, 7'd127);
    issue(ACT_RELEASE, 7'd0);
    issue(ACT_NONE, 7'd127);
    issue(ACT_NONE, 7'd0);
    issue(ACT_RELEASE, 7'd1);
    issue(ACT_ALLOC, 7'd1);
    issue(ACT_QUERY, 7'd1);
    issue(ACT_RELEASE, 7'd64);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 37 : (phase == 1) ? 64 : 0;
      for (int burst = 0; burst < 8; burst++) begin
        case ($urandom_range(2))
          0: alloc_pct = 90;
          1: alloc_pct = 50;
          default: alloc_pct = 15;
        endcase
        repeat (60) begin
          roll = $urandom_range(99);
          if (roll < alloc_pct) begin
            act = ACT_ALLOC;
          end else begin
            roll = $urandom_range(99);
            act = (roll < 45) ? ACT_RELEASE : (roll < 90) ? ACT_QUERY : ACT_NONE;
          end
          if ($urandom_range(99) < 85) num = 7'($urandom_range(NUMBERS, 1));
          else num = 7'($urandom_range(127));
          issue(act, num);
        end
        if (burst == 3) settle();
      end
      settle();
    end

    repeat (100) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
